>>> hw/rtl/pcf_pkg.sv
`timescale 1ns / 1ps

package pcf_pkg;

    // Command codes on the input mode field
    localparam logic [1:0] MODE_SIG  = 2'd0;
    localparam logic [1:0] MODE_OPEN = 2'd1;
    localparam logic [1:0] MODE_DATA = 2'd2;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Command queue between front and back
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef enum logic [1:0] {
        KIND_SIG,
        KIND_OPEN,
        KIND_DATA,
        KIND_ERR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        close;      // chunk CRC follows this command
        logic [30:0] len;
        logic [31:0] tag;
        logic [7:0]  data;
    } t_cmd;

    // One byte of reflected CRC-32
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            3'd7:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/pcf_front.sv
`timescale 1ns / 1ps

module pcf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_full,
    input  logic [1:0]    i_mode,
    input  logic [30:0]   i_chunk_length,
    input  logic [31:0]   i_chunk_tag,
    input  logic [7:0]    i_data_byte,
    output logic          o_q_push,
    output pcf_pkg::t_cmd o_q_cmd
);
    import pcf_pkg::*;

    logic        r_chunk_open, n_chunk_open;
    logic [30:0] r_bytes_rem, n_bytes_rem;
    logic        accept;
    logic        is_err;

    assign accept   = i_push && !i_full;
    assign o_q_push = accept;

    assign is_err = (i_mode != MODE_SIG && i_mode != MODE_OPEN && i_mode != MODE_DATA)
                 || (i_mode == MODE_DATA && !r_chunk_open)
                 || (i_mode != MODE_DATA && r_chunk_open);

    always_comb begin
        o_q_cmd.kind  = KIND_ERR;
        o_q_cmd.close = 1'b0;
        o_q_cmd.len   = i_chunk_length;
        o_q_cmd.tag   = i_chunk_tag;
        o_q_cmd.data  = i_data_byte;
        n_chunk_open  = r_chunk_open;
        n_bytes_rem   = r_bytes_rem;
        if (!is_err) begin
            case (i_mode)
                MODE_SIG: begin
                    o_q_cmd.kind = KIND_SIG;
                end
                MODE_OPEN: begin
                    o_q_cmd.kind  = KIND_OPEN;
                    o_q_cmd.close = (i_chunk_length == 31'd0);
                    n_chunk_open  = (i_chunk_length != 31'd0);
                    n_bytes_rem   = i_chunk_length;
                end
                MODE_DATA: begin
                    o_q_cmd.kind  = KIND_DATA;
                    o_q_cmd.close = (r_bytes_rem == 31'd1);
                    n_chunk_open  = (r_bytes_rem != 31'd1);
                    n_bytes_rem   = r_bytes_rem - 31'd1;
                end
                default: begin
                    o_q_cmd.kind = KIND_ERR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_open <= 1'b0;
            r_bytes_rem  <= '0;
        end else if (accept) begin
            r_chunk_open <= n_chunk_open;
            r_bytes_rem  <= n_bytes_rem;
        end
    end

`ifndef SYNTHESIS
    a_open_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunk_open |-> (r_bytes_rem != 31'd0))
        else $error("open chunk with no bytes pending");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && o_q_cmd.close) |=> !r_chunk_open)
        else $error("chunk still open after close");
`endif

endmodule

>>> hw/rtl/pcf_queue.sv
`timescale 1ns / 1ps

module pcf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pcf_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output pcf_pkg::t_cmd o_cmd
);
    import pcf_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue count overflow");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || o_full) |-> (r_wr == r_rd))
        else $error("queue pointers out of step with count");
`endif

endmodule

>>> hw/rtl/pcf_back.sv
`timescale 1ns / 1ps

module pcf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  pcf_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [7:0]    o_out_byte,
    output logic          o_end_of_run,
    output logic          o_end_of_chunk,
    output logic          o_protocol_error
);
    import pcf_pkg::*;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_eor, r_eoc, r_err;
    logic [31:0] r_crc;
    logic [3:0]  r_step;

    logic        go, at_last;
    logic [3:0]  last_step;
    logic [7:0]  n_byte;
    logic        fold_en, is_crc, n_err;
    logic [7:0]  fold_byte;
    logic [31:0] fold_base, crc_out, len_word;
    logic [1:0]  crc_idx;

    assign go       = !i_q_empty && (!r_out_valid || i_pop);
    assign at_last  = (r_step == last_step);
    assign o_q_pop  = go && at_last;
    assign crc_out  = r_crc ^ CRC_INIT;
    assign len_word = {1'b0, i_q_cmd.len};

    always_comb begin
        n_byte    = 8'd0;
        last_step = 4'd0;
        fold_en   = 1'b0;
        fold_byte = 8'd0;
        is_crc    = 1'b0;
        n_err     = 1'b0;
        crc_idx   = r_step[1:0];
        case (i_q_cmd.kind)
            KIND_SIG: begin
                last_step = 4'd7;
                n_byte    = sig_byte(r_step[2:0]);
            end
            KIND_OPEN: begin
                last_step = i_q_cmd.close ? 4'd11 : 4'd7;
                if (r_step < 4'd4) begin
                    n_byte = len_word[{~r_step[1:0], 3'b000} +: 8];
                end else if (r_step < 4'd8) begin
                    n_byte    = i_q_cmd.tag[{~r_step[1:0], 3'b000} +: 8];
                    fold_en   = 1'b1;
                    fold_byte = n_byte;
                end else begin
                    is_crc = 1'b1;
                    n_byte = crc_out[{~crc_idx, 3'b000} +: 8];
                end
            end
            KIND_DATA: begin
                last_step = i_q_cmd.close ? 4'd4 : 4'd0;
                crc_idx   = 2'(r_step - 4'd1);
                if (r_step == 4'd0) begin
                    n_byte    = i_q_cmd.data;
                    fold_en   = 1'b1;
                    fold_byte = i_q_cmd.data;
                end else begin
                    is_crc = 1'b1;
                    n_byte = crc_out[{~crc_idx, 3'b000} +: 8];
                end
            end
            default: begin
                n_err = 1'b1;
            end
        endcase
    end

    // tag fold always starts a fresh CRC
    assign fold_base = (i_q_cmd.kind == KIND_OPEN && r_step == 4'd4) ? CRC_INIT : r_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_crc       <= CRC_INIT;
            r_step      <= '0;
        end else begin
            if (go) begin
                r_out_valid <= 1'b1;
                r_step      <= at_last ? 4'd0 : r_step + 4'd1;
                if (fold_en) begin
                    r_crc <= crc_fold(fold_base, fold_byte);
                end else if (is_crc && at_last) begin
                    r_crc <= CRC_INIT;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out_byte <= n_byte;
            r_eor      <= at_last;
            r_eoc      <= is_crc && at_last;
            r_err      <= n_err;
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_end_of_run     = r_eor;
    assign o_end_of_chunk   = r_eoc;
    assign o_protocol_error = r_err;

`ifndef SYNTHESIS
    a_eoc_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_eoc) |-> r_eor)
        else $error("chunk end without run end");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_err) |-> (r_out_byte == 8'd0 && r_eor && !r_eoc))
        else $error("error result malformed");
`endif

endmodule

>>> hw/rtl/png_chunk_framer.sv
`timescale 1ns / 1ps

// PNG chunk framer: commands in, framed PNG bytes out.
// Request channel: a queue write port. A request is taken on a clock edge
//   with i_push high and o_full low. i_mode 0 sends the 8-byte signature,
//   1 opens a chunk (length and tag, big-endian), 2 passes one payload byte.
//   Requests out of order, or mode 3, yield one result with the error flag.
// Result channel: a queue read port. The oldest byte sits on o_out_byte
//   while o_empty is low; it is taken on an edge with i_pop high.
//   o_end_of_run marks the last byte of a request, o_end_of_chunk the last
//   CRC byte of a chunk (reflected CRC-32 over tag and payload).
// Structure: the front checks ordering and tracks the payload count, a
//   four-entry command queue follows, and the back sequences bytes, folds the CRC
//   one byte per cycle unless stalled, and holds the result in an output register.
// Path: a taken request is queued; its bytes then go to the output register.
// Throughput: one result byte per cycle unless the queue is empty or i_pop is low.
//   A payload byte yields one byte, plus four CRC bytes at the end of a chunk;
//   signature 8 bytes, open 8 (12 for an empty chunk), set by the back sequencer.
// Stall: while i_pop stays low the output register holds and o_full rises once
//   the queue holds four requests; the one in progress counts until its last byte.
// Reset: synchronous active-low; clears the queue, the output valid flag,
//   the chunk state, and loads the CRC with all ones.

module png_chunk_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_mode,
    input  logic [30:0] i_chunk_length,
    input  logic [31:0] i_chunk_tag,
    input  logic [7:0]  i_data_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_out_byte,
    output logic        o_end_of_run,
    output logic        o_end_of_chunk,
    output logic        o_protocol_error
);
    import pcf_pkg::*;

    t_cmd q_in_cmd, q_out_cmd;
    logic q_push, q_pop, q_empty;

    pcf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .i_full         (o_full),
        .i_mode         (i_mode),
        .i_chunk_length (i_chunk_length),
        .i_chunk_tag    (i_chunk_tag),
        .i_data_byte    (i_data_byte),
        .o_q_push       (q_push),
        .o_q_cmd        (q_in_cmd)
    );

    pcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_full  (o_full),
        .o_empty (q_empty),
        .o_cmd   (q_out_cmd)
    );

    pcf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_cmd          (q_out_cmd),
        .o_q_pop          (q_pop),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_out_byte       (o_out_byte),
        .o_end_of_run     (o_end_of_run),
        .o_end_of_chunk   (o_end_of_chunk),
        .o_protocol_error (o_protocol_error)
    );

endmodule

>>> tb/png_chunk_framer_tb.sv
`timescale 1ns / 1ps

module png_chunk_framer_tb;
    import pcf_pkg::*;

    // Mode 3 has no name in the package; it must always be rejected
    localparam logic [1:0]  MODE_UNUSED        = 2'd3;
    // PNG file signature, first byte in the top bits
    localparam logic [63:0] PNG_MAGIC          = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [31:0] CRC_SEED           = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_REFLECTED_POLY = 32'hEDB8_8320;
    localparam logic [31:0] TAG_IHDR           = 32'h4948_4452;
    localparam logic [31:0] TAG_IDAT           = 32'h4944_4154;
    localparam logic [31:0] TAG_IEND           = 32'h4945_4E44;
    localparam logic [31:0] TAG_TEXT           = 32'h7445_5874;
    localparam logic [30:0] LEN_MAX            = 31'h7FFF_FFFF;
    localparam int          RANDOM_REQUESTS    = 450;
    localparam int          IDLE_PERCENT       = 29;
    localparam int          DRAIN_CYCLES       = 16;
    localparam int          CYCLE_LIMIT        = 200000;

    // One framed output byte with its flags
    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
        logic       end_of_chunk;
        logic       protocol_error;
    } t_frame_byte;

    // Framing predictor plus the queue of bytes the block still owes us.
    class framer_scoreboard;
        logic [31:0] crc_reg;
        logic [30:0] bytes_left;
        bit          in_chunk;
        t_frame_byte pending[$];
        int          mismatches;
        int          requests;
        int          bad_requests;
        int          chunks_closed;
        int          bytes_checked;

        function new();
            crc_reg       = CRC_SEED;
            bytes_left    = '0;
            in_chunk      = 1'b0;
            mismatches    = 0;
            requests      = 0;
            bad_requests  = 0;
            chunks_closed = 0;
            bytes_checked = 0;
        endfunction

        // Reflected CRC-32, one data bit at a time
        function logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
            logic fb;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c  = c >> 1;
                if (fb)
                    c = c ^ CRC_REFLECTED_POLY;
            end
            return c;
        endfunction

        function void queue_byte(logic [7:0] b, logic eoc);
            t_frame_byte f;
            f.out_byte       = b;
            f.end_of_run     = 1'b0;
            f.end_of_chunk   = eoc;
            f.protocol_error = 1'b0;
            pending = {pending, f};
        endfunction

        // Big-endian word; eoc only on the low byte
        function void queue_word(logic [31:0] w, logic eoc);
            queue_byte(w[31:24], 1'b0);
            queue_byte(w[23:16], 1'b0);
            queue_byte(w[15:8], 1'b0);
            queue_byte(w[7:0], eoc);
        endfunction

        function void close_chunk();
            queue_word(crc_reg ^ CRC_SEED, 1'b1);
            crc_reg    = CRC_SEED;
            bytes_left = '0;
            in_chunk   = 1'b0;
            chunks_closed++;
        endfunction

        // Called on each accepted request
        function void note_request(logic [1:0] mode, logic [30:0] len,
                                   logic [31:0] tag, logic [7:0] data);
            t_frame_byte last;
            requests++;
            // data only inside a chunk, everything else only outside
            if (mode == MODE_UNUSED || ((mode == MODE_DATA) != in_chunk)) begin
                last.out_byte       = 8'h00;
                last.end_of_run     = 1'b1;
                last.end_of_chunk   = 1'b0;
                last.protocol_error = 1'b1;
                pending = {pending, last};
                bad_requests++;
                return;
            end
            case (mode)
                MODE_SIG: begin
                    for (int i = 0; i < 8; i++)
                        queue_byte(PNG_MAGIC[63 - 8 * i -: 8], 1'b0);
                end
                MODE_OPEN: begin
                    queue_word({1'b0, len}, 1'b0);
                    queue_word(tag, 1'b0);
                    crc_reg = CRC_SEED;
                    for (int i = 3; i >= 0; i--)
                        crc_reg = crc_byte(crc_reg, tag[8 * i +: 8]);
                    bytes_left = len;
                    in_chunk   = 1'b1;
                    if (len == '0)
                        close_chunk();
                end
                default: begin
                    queue_byte(data, 1'b0);
                    crc_reg    = crc_byte(crc_reg, data);
                    bytes_left = bytes_left - 31'd1;
                    if (bytes_left == '0)
                        close_chunk();
                end
            endcase
            last = pending.pop_back();
            last.end_of_run = 1'b1;
            pending = {pending, last};
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [7:0] b, logic eor, logic eoc, logic perr);
            t_frame_byte want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("byte %02h arrived with nothing expected", b));
                return;
            end
            want = pending.pop_front();
            bytes_checked++;
            if (b !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, want %02h", b, want.out_byte));
            if (eor !== want.end_of_run)
                report_mismatch($sformatf("end_of_run %b, want %b", eor, want.end_of_run));
            if (eoc !== want.end_of_chunk)
                report_mismatch($sformatf("end_of_chunk %b, want %b", eoc,
                                          want.end_of_chunk));
            if (perr !== want.protocol_error)
                report_mismatch($sformatf("protocol_error %b, want %b", perr,
                                          want.protocol_error));
        endtask
    endclass

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_push           = 1'b0;
    logic [1:0]  i_mode           = MODE_SIG;
    logic [30:0] i_chunk_length   = '0;
    logic [31:0] i_chunk_tag      = '0;
    logic [7:0]  i_data_byte      = '0;
    logic        i_pop            = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [7:0]  o_out_byte;
    logic        o_end_of_run;
    logic        o_end_of_chunk;
    logic        o_protocol_error;

    // When set, neither side idles
    bit          steady           = 1'b0;
    int          cycle_count      = 0;

    framer_scoreboard board = new();

    png_chunk_framer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_mode          (i_mode),
        .i_chunk_length  (i_chunk_length),
        .i_chunk_tag     (i_chunk_tag),
        .i_data_byte     (i_data_byte),
        .o_empty         (o_empty),
        .i_pop           (i_pop),
        .o_out_byte      (o_out_byte),
        .o_end_of_run    (o_end_of_run),
        .o_end_of_chunk  (o_end_of_chunk),
        .o_protocol_error(o_protocol_error)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: a stuck handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes still owed",
                     cycle_count, board.pending.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: signals read here are the pre-edge values, so the pop
    // decided last cycle and the byte on the ports belong together.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_pop && !o_empty)
                board.check_result(o_out_byte, o_end_of_run, o_end_of_chunk,
                                   o_protocol_error);
            i_pop <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Present one request, idling first at random, and hold it until the
    // block takes it. The predictor sees it at the accepting edge.
    task automatic send_request(input logic [1:0] mode, input logic [30:0] len,
                                input logic [31:0] tag, input logic [7:0] data);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push         <= 1'b1;
        i_mode         <= mode;
        i_chunk_length <= len;
        i_chunk_tag    <= tag;
        i_data_byte    <= data;
        @(posedge i_clk);
        while (o_full)
            @(posedge i_clk);
        board.note_request(mode, len, tag, data);
    endtask

    // Drop push and hold off until every owed byte has come out
    task automatic wait_drained();
        i_push <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly well-formed chunk streams with random content; about one
    // request in ten is deliberately out of order with random fields.
    task automatic run_random(input int count);
        int          issued;
        int          roll;
        logic [1:0]  mode;
        logic [30:0] len;
        issued = 0;
        while (issued < count || board.in_chunk) begin
            // a long window with no idling on either side
            steady <= (issued >= 150 && issued < 250);
            // once mid-run, let the result side catch up completely
            if (issued == 300)
                wait_drained();
            roll = $urandom_range(99);
            if (roll < 10 && issued < count) begin
                if (board.in_chunk) begin
                    case ($urandom_range(2))
                        0:       mode = MODE_SIG;
                        1:       mode = MODE_OPEN;
                        default: mode = MODE_UNUSED;
                    endcase
                end else begin
                    mode = $urandom_range(1) ? MODE_DATA : MODE_UNUSED;
                end
                send_request(mode, 31'($urandom()), $urandom(), 8'($urandom_range(255)));
            end else if (board.in_chunk) begin
                send_request(MODE_DATA, 31'($urandom()), $urandom(),
                             8'($urandom_range(255)));
            end else if (roll < 22) begin
                send_request(MODE_SIG, 31'($urandom()), $urandom(),
                             8'($urandom_range(255)));
            end else begin
                // mostly short chunks, some empty, a few longer
                roll = $urandom_range(99);
                if (roll < 25)
                    len = '0;
                else if (roll < 85)
                    len = 31'($urandom_range(8, 1));
                else
                    len = 31'($urandom_range(40, 9));
                send_request(MODE_OPEN, len, $urandom(), 8'($urandom_range(255)));
            end
            issued++;
        end
        steady <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: rejects from the idle state
        send_request(MODE_DATA, '0, '0, 8'hFF);
        send_request(MODE_UNUSED, LEN_MAX, 32'hFFFF_FFFF, 8'hFF);
        // Signature, then empty chunks that close at once
        send_request(MODE_SIG, '0, '0, 8'h00);
        send_request(MODE_OPEN, '0, TAG_IEND, 8'h00);
        send_request(MODE_OPEN, '0, 32'hFFFF_FFFF, 8'hFF);
        send_request(MODE_OPEN, '0, 32'h0000_0000, 8'h00);
        // One-byte chunk
        send_request(MODE_OPEN, 31'd1, TAG_IHDR, 8'h00);
        send_request(MODE_DATA, '0, '0, 8'h00);
        // Chunk with every kind of reject in the middle; CRC must survive them
        send_request(MODE_OPEN, 31'd4, TAG_TEXT, 8'h00);
        send_request(MODE_DATA, '0, '0, 8'hFF);
        send_request(MODE_SIG, '0, '0, 8'h00);
        send_request(MODE_OPEN, LEN_MAX, 32'hFFFF_FFFF, 8'h00);
        send_request(MODE_UNUSED, '0, '0, 8'h00);
        send_request(MODE_DATA, '0, '0, 8'h55);
        send_request(MODE_DATA, '0, '0, 8'hAA);
        send_request(MODE_DATA, '0, '0, 8'h80);
        send_request(MODE_SIG, '0, '0, 8'h00);

        run_random(RANDOM_REQUESTS);

        // Last: a chunk of maximum length, which stays open to the end
        send_request(MODE_OPEN, LEN_MAX, TAG_IDAT, 8'h00);
        send_request(MODE_DATA, '0, '0, 8'hFF);
        send_request(MODE_DATA, '0, '0, 8'h00);
        send_request(MODE_OPEN, 31'h2AAA_AAAA, 32'h1234_5678, 8'h00);
        send_request(MODE_SIG, '0, '0, 8'h00);
        send_request(MODE_DATA, '0, '0, 8'h5A);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests, %0d of them out of order; %0d chunks closed",
                 board.requests, board.bad_requests, board.chunks_closed);
        $display("Checked %0d framed bytes in %0d cycles", board.bytes_checked,
                 cycle_count);
        if (board.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/pcf_pkg.sv
hw/rtl/pcf_front.sv
hw/rtl/pcf_queue.sv
hw/rtl/pcf_back.sv
hw/rtl/png_chunk_framer.sv
tb/png_chunk_framer_tb.sv
